// File: sv/plist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_pkg
// Shared constants and controller/datapath interface types for the
// positional integer list.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 9;
  localparam int OUT_CNT_W = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;     // latch the input transaction
    logic init;     // set shift pointers and status
    logic rd;       // read the neighbor of the pointer
    logic wr;       // write it back one place over, step the pointer
    logic fin;      // place the new value or drop the count
    logic rd_elem;  // read the element at position
    logic emit;     // register the result
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       range_err;
    logic       shift_done;
  } dp_stat_t;

endpackage

// File: sv/plist_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_ctrl
// Sequencer for the list: decodes the operation, steps the element shift
// one read/write pair at a time, then issues the result.
// ----------------------------------------------------------------------------
module plist_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plist_pkg::dp_stat_t stat,
  output plist_pkg::ctl_cmd_t cmd
);
  import plist_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INIT     = 7'b0000010,
    S_CHECK    = 7'b0000100,
    S_SHIFT_WR = 7'b0001000,
    S_FIN      = 7'b0010000,
    S_RD_ELEM  = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init = 1'b1;
        priority if (stat.op == OP_INSERT && !stat.full) begin
          state_nxt = S_CHECK;
        end else if (stat.op == OP_REMOVE && !stat.empty) begin
          state_nxt = S_CHECK;
        end else if (stat.op == OP_READ && !stat.range_err) begin
          state_nxt = S_RD_ELEM;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_CHECK: begin
        if (stat.shift_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_RD_ELEM: begin
        cmd.rd_elem = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/plist_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_dp
// List storage and bookkeeping: element memory, fill count, shift pointer
// and the registered result.
// ----------------------------------------------------------------------------
module plist_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  plist_pkg::ctl_cmd_t                  cmd,
  output plist_pkg::dp_stat_t                  stat,
  input  logic [1:0]                           in_opcode,
  input  logic signed [plist_pkg::POS_W-1:0]   in_position,
  input  logic signed [plist_pkg::VAL_W-1:0]   in_new_value,
  output logic                                 out_valid,
  output logic signed [plist_pkg::VAL_W-1:0]   out_read_value,
  output logic [plist_pkg::OUT_CNT_W-1:0]      out_element_count,
  output logic                                 out_is_empty,
  output logic [1:0]                           out_status
);
  import plist_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];

  logic [1:0]       op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] end_r;
  logic [1:0]       st_r;
  logic [VAL_W-1:0] rdata_r;

  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_value_r;
  logic [CNT_W-1:0]     out_count_r;
  logic [1:0]           out_status_r;

  logic             full;
  logic             empty;
  logic             pos_le0;
  logic [7:0]       pos_u;
  logic             range_err;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] idx_ins;
  logic [IDX_W-1:0] idx_rem;
  logic             is_ins;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [VAL_W-1:0] wdata;
  logic [IDX_W-1:0] raddr;
  logic [1:0]       st_nxt;

  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign pos_le0  = pos_r[POS_W-1] || (pos_r == '0);
  assign pos_u    = pos_r[7:0];
  assign range_err = pos_r[POS_W-1] || ({1'b0, pos_u} >= {2'b00, count_r});
  assign count_m1 = count_r - 1'b1;
  assign is_ins   = (op_r == OP_INSERT);

  // clamp to [0, count] for insert and [0, count-1] for remove
  always_comb begin
    if (pos_le0) begin
      idx_ins = '0;
      idx_rem = '0;
    end else begin
      idx_ins = ({1'b0, pos_u} > {2'b00, count_r}) ? count_r[IDX_W-1:0] : pos_u[IDX_W-1:0];
      idx_rem = ({1'b0, pos_u} > {2'b00, count_m1}) ? count_m1[IDX_W-1:0]
                                                    : pos_u[IDX_W-1:0];
    end
  end

  always_comb begin
    priority if (is_ins && full) begin
      st_nxt = ST_FULL;
    end else if (op_r == OP_REMOVE && empty) begin
      st_nxt = ST_EMPTY;
    end else if (op_r == OP_READ && range_err) begin
      st_nxt = ST_RANGE;
    end else begin
      st_nxt = ST_OK;
    end
  end

  assign stat.op         = op_r;
  assign stat.full       = full;
  assign stat.empty      = empty;
  assign stat.range_err  = range_err;
  assign stat.shift_done = (ptr_r == end_r);

  // insert moves elements up, walking down from the tail; remove walks up
  assign raddr = cmd.rd_elem ? pos_u[IDX_W-1:0]
               : (is_ins ? ptr_r - 1'b1 : ptr_r + 1'b1);
  assign we    = cmd.wr || (cmd.fin && is_ins);
  assign waddr = cmd.wr ? ptr_r : end_r;
  assign wdata = cmd.wr ? rdata_r : val_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd || cmd.rd_elem) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      pos_r <= in_position;
      val_r <= in_new_value;
    end
    if (cmd.init) begin
      st_r  <= st_nxt;
      ptr_r <= is_ins ? count_r[IDX_W-1:0] : idx_rem;
      end_r <= is_ins ? idx_ins : count_m1[IDX_W-1:0];
    end else if (cmd.wr) begin
      ptr_r <= is_ins ? ptr_r - 1'b1 : ptr_r + 1'b1;
    end
    if (cmd.emit) begin
      out_value_r  <= (op_r == OP_READ && st_r == ST_OK) ? rdata_r : '0;
      out_count_r  <= count_r;
      out_status_r <= st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.fin) begin
        count_r <= is_ins ? count_r + 1'b1 : count_m1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_value_r;
  assign out_element_count = OUT_CNT_W'(out_count_r);
  assign out_is_empty      = (out_count_r == '0);
  assign out_status        = out_status_r;

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> out_count_r == CNT_W'(CAPACITY))
    else $error("full status reported with list not at capacity");

  a_wr_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> ptr_r != end_r)
    else $error("shift write issued past the target index");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin && is_ins |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the count by one");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> !(is_ins && full) && !(!is_ins && empty))
    else $error("list changed on a full insert or empty remove");

endmodule

// File: sv/positional_list_insert_remove_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_remove_top
// Ordered list of up to 64 signed 32-bit values with positional insert,
// remove and read; one result per command.
// ----------------------------------------------------------------------------
// sequence: INIT, then a read/write pair per shifted element and FIN for insert/remove,
//   RD_ELEM for a read, none for a rejected command or no-op; EMIT registers out_valid
// throughput: one command at a time, a new one taken only while busy is low;
//   each shifted element costs a registered read and a write; busy drops as out_valid shows
// out_valid is a one-cycle strobe; the receiver cannot stall
// reset: synchronous active-low rst_n empties the list; contents not cleared
module positional_list_insert_remove_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_opcode,
  input  logic signed [plist_pkg::POS_W-1:0]   in_position,
  input  logic signed [plist_pkg::VAL_W-1:0]   in_new_value,
  output logic                                 out_valid,
  output logic signed [plist_pkg::VAL_W-1:0]   out_read_value,
  output logic [plist_pkg::OUT_CNT_W-1:0]      out_element_count,
  output logic                                 out_is_empty,
  output logic [1:0]                           out_status
);
  import plist_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  plist_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  plist_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_opcode),
    .in_position       (in_position),
    .in_new_value      (in_new_value),
    .out_valid         (out_valid),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty),
    .out_status        (out_status)
  );

endmodule

// File: tb/list_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_result_checker
// Watches the command and result channels of the positional list, keeps a
// shadow copy of the list, predicts the result of every accepted command
// and compares each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module list_result_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [1:0]                          in_opcode,
  input  logic signed [plist_pkg::POS_W-1:0]  in_position,
  input  logic signed [plist_pkg::VAL_W-1:0]  in_new_value,
  input  logic                                out_valid,
  input  logic signed [plist_pkg::VAL_W-1:0]  out_read_value,
  input  logic [plist_pkg::OUT_CNT_W-1:0]     out_element_count,
  input  logic                                out_is_empty,
  input  logic [1:0]                          out_status,
  output int                                  errors,
  output int                                  outstanding
);
  import plist_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic [OUT_CNT_W-1:0]    element_count;
    logic                    is_empty;
    logic [1:0]              status;
  } list_result_t;

  logic signed [VAL_W-1:0] shadow_list [CAPACITY];
  int                      shadow_count = 0;
  list_result_t            awaited_results [$];
  int                      error_total = 0;
  int                      waiting = 0;

  assign errors      = error_total;
  assign outstanding = waiting;

  // updates the shadow list and returns the result the command should give
  task automatic apply_list_op(input logic [1:0] op, input logic signed [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] val, output list_result_t res);
    int p;
    int idx;
    int i;
    p = int'(pos);
    res.read_value = '0;
    res.status     = ST_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          idx = (p <= 0) ? 0 : ((p > shadow_count) ? shadow_count : p);
          for (i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[idx] = val;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          idx = (p <= 0) ? 0 : ((p > shadow_count - 1) ? shadow_count - 1 : p);
          for (i = idx; i < shadow_count - 1; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      OP_READ: begin
        if (p < 0 || p >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = shadow_list[p];
        end
      end
      default: ;  // no-op code leaves the list alone
    endcase
    res.element_count = shadow_count[OUT_CNT_W-1:0];
    res.is_empty      = (shadow_count == 0);
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      awaited_results.delete();
    end else begin
      // retire the result before taking a transaction on the same edge
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          error_total++;
          $error("result strobe with no transaction outstanding");
        end else begin
          want = awaited_results.pop_front();
          if (out_read_value !== want.read_value) begin
            error_total++;
            $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
          end
          if (out_element_count !== want.element_count) begin
            error_total++;
            $error("element_count: expected %0d, got %0d", want.element_count,
                   out_element_count);
          end
          if (out_is_empty !== want.is_empty) begin
            error_total++;
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_is_empty);
          end
          if (out_status !== want.status) begin
            error_total++;
            $error("status: expected %0d, got %0d", want.status, out_status);
          end
        end
      end
      if (start && !busy) begin
        apply_list_op(in_opcode, in_position, in_new_value, want);
        awaited_results.push_back(want);
      end
    end
    waiting = awaited_results.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the positional list with a directed set of corner-case commands,
// then with phases of insert-heavy, remove-heavy and mixed random traffic
// with random idle bursts; a checker beside the block scores every result.
// ----------------------------------------------------------------------------
module testbench;
  import plist_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 140;
  localparam int PHASE_ITEMS  = 210;
  localparam int NUM_PHASES   = 6;
  localparam int TAIL_ITEMS   = 150;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic                    clk;
  logic                    rst_n        = 1'b0;
  logic                    start        = 1'b0;
  logic [1:0]              in_opcode    = OP_NOP;
  logic signed [POS_W-1:0] in_position  = '0;
  logic signed [VAL_W-1:0] in_new_value = '0;

  logic                    busy;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_read_value;
  logic [OUT_CNT_W-1:0]    out_element_count;
  logic                    out_is_empty;
  logic [1:0]              out_status;

  int          errors;
  int          outstanding;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  positional_list_insert_remove_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_position       (in_position),
    .in_new_value      (in_new_value),
    .out_valid         (out_valid),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty),
    .out_status        (out_status)
  );

  list_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_position       (in_position),
    .in_new_value      (in_new_value),
    .out_valid         (out_valid),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty),
    .out_status        (out_status),
    .errors            (errors),
    .outstanding       (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that accepts the transaction
  // with start still high, so a following command keeps it high
  task automatic issue(input logic [1:0] op, input logic signed [POS_W-1:0] pos,
                       input logic signed [VAL_W-1:0] val);
    start        <= 1'b1;
    in_opcode    <= op;
    in_position  <= pos;
    in_new_value <= val;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int k;
    int r;
    int ins_pct;
    int rem_pct;
    int idle_pct;
    int item_no;
    logic [1:0]              op;
    logic signed [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] val;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners on an empty and a short list
    issue(OP_READ,   9'sd0,    32'sd0);
    issue(OP_REMOVE, 9'sd0,    32'sd0);
    issue(OP_NOP,    9'sd0,    32'sd0);
    issue(OP_INSERT, -9'sd1,   VAL_MAX);
    issue(OP_INSERT, 9'sd0,    VAL_MIN);
    issue(OP_INSERT, 9'sd255,  32'sd0);
    issue(OP_INSERT, -9'sd256, -32'sd1);
    issue(OP_INSERT, 9'sd2,    32'sh5555_5555);
    issue(OP_INSERT, 9'sd100,  32'shaaaa_aaaa);
    issue(OP_READ,   9'sd0,    32'sd0);
    issue(OP_READ,   9'sd5,    32'sd0);
    issue(OP_READ,   9'sd6,    32'sd0);
    issue(OP_READ,   -9'sd1,   32'sd0);
    issue(OP_READ,   9'sd255,  32'sd0);
    issue(OP_READ,   -9'sd256, 32'sd0);
    issue(OP_NOP,    9'sh0aa,  32'h1234_5678);
    issue(OP_REMOVE, -9'sd1,   32'sd0);
    issue(OP_REMOVE, 9'sd255,  32'sd0);
    issue(OP_REMOVE, 9'sd1,    32'sd0);
    issue(OP_REMOVE, -9'sd256, 32'sd0);
    issue(OP_READ,   9'sd1,    32'sd0);
    issue(OP_REMOVE, 9'sd0,    32'sd0);
    issue(OP_REMOVE, 9'sd0,    32'sd0);
    issue(OP_REMOVE, 9'sd3,    32'sd0);

    // random phases: grow, shrink, grow, mixed, shrink, mixed
    item_no = 0;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0, 2:    begin ins_pct = 72; rem_pct = 14; end
        1, 4:    begin ins_pct = 14; rem_pct = 72; end
        default: begin ins_pct = 42; rem_pct = 35; end
      endcase
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) op = OP_INSERT;
        else if (r < ins_pct + rem_pct) op = OP_REMOVE;
        else if (r < 97) op = OP_READ;
        else op = OP_NOP;
        // mostly around the live range, sometimes any 9-bit code
        if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom);
        else pos = POS_W'($urandom_range(0, 70));
        case ($urandom_range(0, 19))
          0:       val = VAL_MAX;
          1:       val = VAL_MIN;
          2:       val = '0;
          default: val = $urandom;
        endcase
        issue(op, pos, val);
        item_no++;
        if (item_no < NUM_PHASES * PHASE_ITEMS - TAIL_ITEMS &&
            $urandom_range(0, 99) < idle_pct)
          idle($urandom_range(1, 7));
      end
    end

    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (outstanding != 0)
      $error("%0d transactions never produced a result", outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/plist_pkg.sv
sv/plist_ctrl.sv
sv/plist_dp.sv
sv/positional_list_insert_remove_top.sv
tb/list_result_checker.sv
tb/testbench.sv
